@@ rtl/periodic_task_timer_table_assert.svh @@
// assertion helpers shared by the rtl
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// condition holds in the same cycle
`define PTT_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// condition holds in the following cycle
`define PTT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ rtl/ptt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

   localparam int SLOTS     = 16;
   localparam int TIME_BITS = 32;
   localparam int SLOT_W    = 4;
   localparam int RUNS_W    = 16;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_ADD  = 2'd1;
   localparam logic [1:0] CMD_DEL  = 2'd2;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [SLOT_W-1:0]    slot;
      logic [TIME_BITS-1:0] first_due;
      logic [TIME_BITS-1:0] interval;
      logic [RUNS_W-1:0]    run_limit;
   } ptt_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    fired_slot;
      logic                 none_fired;
      logic                 retired;
      logic [TIME_BITS-1:0] now_time;
      logic                 last;
   } ptt_rsp_type;

   typedef struct packed {
      logic add;
      logic del;
   } ptt_wr_type;

   typedef struct packed {
      logic fire;
      logic retire;
   } ptt_hit_type;

endpackage
`default_nettype wire

@@ rtl/ptt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ptt_cell import ptt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ptt_wr_type           wr,
   input  logic [TIME_BITS-1:0] first_due,
   input  logic [TIME_BITS-1:0] interval,
   input  logic [RUNS_W-1:0]    run_limit,
   input  logic [TIME_BITS-1:0] time_now,
   input  logic                 shift,
   input  logic                 tok_in,
   output logic                 tok_out,
   output ptt_hit_type          hit
);

   logic                 valid_ff, valid_in;
   logic                 tok_ff, tok_ff_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [TIME_BITS-1:0] ival_ff, ival_in;
   logic [RUNS_W-1:0]    runs_ff, runs_in;
   logic                 fire;

   assign fire       = tok_ff && valid_ff && (due_ff == time_now);
   assign hit.fire   = fire;
   assign hit.retire = fire && (runs_ff == RUNS_W'(1));
   assign tok_out    = tok_ff;
   assign tok_ff_in  = shift ? tok_in : tok_ff;

   always_comb begin
      valid_in = valid_ff;
      due_in   = due_ff;
      ival_in  = ival_ff;
      runs_in  = runs_ff;
      priority if (wr.add) begin
         valid_in = 1'b1;
         due_in   = first_due;
         ival_in  = interval;
         runs_in  = run_limit;
      end else if (wr.del) begin
         valid_in = 1'b0;
      end else if (fire && shift) begin
         due_in = time_now + ival_ff;
         if (runs_ff != '0) begin
            runs_in = runs_ff - RUNS_W'(1);
            if (runs_ff == RUNS_W'(1)) begin
               valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff  <= due_in;
      ival_ff <= ival_in;
      runs_ff <= runs_in;
   end

endmodule
`default_nettype wire

@@ rtl/periodic_task_timer_table.sv @@
// periodic task timer table
//
// requests enter on req_* (valid/stall). a tick request advances the time by
// one and walks a token down a row of sixteen slot cells, one cell per clock
// unless rsp_stall holds it back. each due slot is rescheduled and reported
// on rsp_*, in slot order, with last set on the final response of that tick;
// a tick with no due slot gives one response with none_fired set. add and
// delete requests give no response. a tick request launches the token into the
// first cell as it is accepted, walks the sixteen cells, then sends the last
// response; req_stall stays high from the walk through that last response.
// responses sit in an output register; when rsp_stall holds it, the walk
// pauses at the next due cell until the register frees up.
// reset (synchronous) clears the time, frees all slots and empties the
// output register.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_timer_table_assert.svh"
module periodic_task_timer_table import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ptt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ptt_rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic                 pend_retire_ff, pend_retire_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ptt_rsp_type          rsp_data_ff, rsp_data_in;

   ptt_wr_type           wr   [SLOTS];
   ptt_hit_type          hits [SLOTS];
   logic [SLOTS:0]       tok;
   logic [SLOTS-1:0]     tok_vec;
   ptt_hit_type          hit;

   logic req_acc, tick_acc, out_free, scan_en, shift;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign tick_acc  = req_acc && (req_data.cmd == CMD_TICK);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_en   = !(hit.fire && pend_valid_ff && !out_free);
   assign shift     = tick_acc || ((state_ff == ST_SCAN) && scan_en);
   assign tok[0]    = tick_acc;
   assign tok_vec   = tok[SLOTS:1];

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      assign wr[g].add = req_acc && (req_data.cmd == CMD_ADD) &&
                         (req_data.slot == SLOT_W'(g));
      assign wr[g].del = req_acc && (req_data.cmd == CMD_DEL) &&
                         (req_data.slot == SLOT_W'(g));
      ptt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr        (wr[g]),
         .first_due (req_data.first_due),
         .interval  (req_data.interval),
         .run_limit (req_data.run_limit),
         .time_now  (time_ff),
         .shift     (shift),
         .tok_in    (tok[g]),
         .tok_out   (tok[g+1]),
         .hit       (hits[g])
      );
   end

   // only the cell holding the token can report a hit
   always_comb begin
      hit = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit.fire   = hit.fire   | hits[i].fire;
         hit.retire = hit.retire | hits[i].retire;
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      time_in        = time_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_retire_in = pend_retire_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               time_in       = time_ff + TIME_BITS'(1);
               idx_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_en) begin
               if (hit.fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.fired_slot = pend_slot_ff;
                     rsp_data_in.none_fired = 1'b0;
                     rsp_data_in.retired    = pend_retire_ff;
                     rsp_data_in.now_time   = time_ff;
                     rsp_data_in.last       = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_slot_in   = idx_ff;
                  pend_retire_in = hit.retire;
               end
               idx_in = idx_ff + SLOT_W'(1);
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.fired_slot = pend_valid_ff ? pend_slot_ff : '0;
               rsp_data_in.none_fired = !pend_valid_ff;
               rsp_data_in.retired    = pend_valid_ff && pend_retire_ff;
               rsp_data_in.now_time   = time_ff;
               rsp_data_in.last       = 1'b1;
               pend_valid_in          = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         time_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         time_ff       <= time_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff   <= pend_slot_in;
      pend_retire_ff <= pend_retire_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PTT_ASSERT_NOW(a_tok_single, clock, reset, 1'b1, $onehot0(tok_vec))
   `PTT_ASSERT_NOW(a_tok_scan, clock, reset, state_ff == ST_SCAN, $onehot(tok_vec))
   `PTT_ASSERT_NOW(a_tok_idle, clock, reset, state_ff != ST_SCAN, tok_vec == '0)
   `PTT_ASSERT_NEXT(a_flush_last, clock, reset, (state_ff == ST_FLUSH) && out_free,
      rsp_valid_ff && rsp_data_ff.last && (state_ff == ST_IDLE))

endmodule
`default_nettype wire
